/* sv/ris_pkg.sv */
package ris_pkg;

    localparam int SUM_BITS = 64;
    localparam int COALESCED_IN_BITS = 32;
    localparam int OUTCOME_BITS = 2;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_ACCEPT = 2'd1,
        MODE_REJECT = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    localparam logic [OUTCOME_BITS-1:0] OUTCOME_OK     = 2'd0;
    localparam logic [OUTCOME_BITS-1:0] OUTCOME_FAILED = 2'd1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    typedef struct packed {
        logic apply;
        logic div_start;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_stat;

endpackage

/* sv/report_interval_statistics.sv */
// Channel    Direction  tdata fields (lowest bit up)                        tuser
// s_axis     in         timestamp_us, send_outcome, merged_count            mode
// m_axis     out        tick_total ... coalesced_sum (snapshot)             status
//
// A report tick that measures an interval raises its result once the radix-2 divider, which
// retires one quotient bit of the 64-bit interval sum per cycle, is done; every other item
// goes straight to the load state. A result is loaded once the output register is free, and
// s_axis_tready rises with m_axis_tvalid, so no new item is taken before the last result is
// raised. The synchronous active-low reset clears all statistics.
// A finished result waits in the output register while the next item is taken in.
module report_interval_statistics #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // timestamp_us, send_outcome, merged_count
    input  logic [((TIME_BITS + 34 + 7) / 8) * 8 - 1:0]                      s_axis_tdata,
    // mode
    input  logic [1:0]              s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // tick_total, send_ok_total, send_failed_total, interval_total_count,
    // interval_average, interval_maximum, accepted_total, rejected_total, coalesced_sum
    output logic [((6 * COUNT_BITS + 3 * TIME_BITS + 7) / 8) * 8 - 1:0]     m_axis_tdata,
    // status
    output logic                    m_axis_tuser
);
    import ris_pkg::*;

    localparam int OUT_W = ((6 * COUNT_BITS + 3 * TIME_BITS + 7) / 8) * 8;
    localparam int OC_LO = TIME_BITS;
    localparam int CU_LO = TIME_BITS + OUTCOME_BITS;

    t_cmd  cmd;
    t_stat stat;

    ris_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    ris_datapath #(
        .TIME_BITS  (TIME_BITS),
        .COUNT_BITS (COUNT_BITS),
        .OUT_W      (OUT_W)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_mode              (s_axis_tuser),
        .i_timestamp_us      (s_axis_tdata[TIME_BITS-1:0]),
        .i_send_outcome      (s_axis_tdata[OC_LO +: OUTCOME_BITS]),
        .i_merged_count      (s_axis_tdata[CU_LO +: COALESCED_IN_BITS]),
        .o_status            (m_axis_tuser),
        .o_data              (m_axis_tdata)
    );

endmodule

/* sv/ris_div.sv */
module ris_div #(
    parameter int COUNT_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [ris_pkg::SUM_BITS-1:0]   i_dividend,
    input  logic [COUNT_BITS-1:0]          i_divisor,
    output logic                           o_done,
    output logic [ris_pkg::SUM_BITS-1:0]   o_quotient
);
    import ris_pkg::*;

    localparam int STEP_BITS = $clog2(SUM_BITS);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_BITS-1:0]  r_step;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_div;
    logic [SUM_BITS-1:0]   r_quo;
    logic [COUNT_BITS:0]   n_shift;
    logic [COUNT_BITS:0]   n_diff;
    logic                  n_ge;

    always_comb begin
        n_shift = {r_rem, r_quo[SUM_BITS-1]};
        n_diff  = n_shift - {1'b0, r_div};
        n_ge    = ~n_diff[COUNT_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_step == STEP_BITS'(SUM_BITS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_BITS'(SUM_BITS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_div <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[COUNT_BITS-1:0] : n_shift[COUNT_BITS-1:0];
            r_quo <= {r_quo[SUM_BITS-2:0], n_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* sv/ris_datapath.sv */
module ris_datapath #(
    parameter int TIME_BITS  = 48,
    parameter int COUNT_BITS = 32,
    parameter int OUT_W      = 336
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  ris_pkg::t_cmd                           i_cmd,
    output ris_pkg::t_stat                          o_stat,
    input  logic [1:0]                              i_mode,
    input  logic [TIME_BITS-1:0]                    i_timestamp_us,
    input  logic [ris_pkg::OUTCOME_BITS-1:0]        i_send_outcome,
    input  logic [ris_pkg::COALESCED_IN_BITS-1:0]   i_merged_count,
    output logic                                    o_status,
    output logic [OUT_W-1:0]                        o_data
);
    import ris_pkg::*;

    localparam int CO_W = ((TIME_BITS > COALESCED_IN_BITS) ? TIME_BITS : COALESCED_IN_BITS) + 1;
    localparam logic [TIME_BITS-1:0] TMAX = {TIME_BITS{1'b1}};
    localparam logic [SUM_BITS-1:0] TMAX_EXT = SUM_BITS'((65'd1 << TIME_BITS) - 65'd1);

    logic [TIME_BITS-1:0]  r_prev_time;
    logic                  r_have_prev;
    logic [COUNT_BITS-1:0] r_tick;
    logic [COUNT_BITS-1:0] r_ok;
    logic [COUNT_BITS-1:0] r_failed;
    logic [COUNT_BITS-1:0] r_icount;
    logic [SUM_BITS-1:0]   r_isum;
    logic [TIME_BITS-1:0]  r_avg;
    logic [TIME_BITS-1:0]  r_max;
    logic [COUNT_BITS-1:0] r_accepted;
    logic [COUNT_BITS-1:0] r_rejected;
    logic [TIME_BITS-1:0]  r_coal;
    logic                  r_status;
    logic                  r_out_status;
    logic [OUT_W-1:0]      r_out_data;

    t_mode                 n_mode;
    logic                  n_bad;
    logic [TIME_BITS-1:0]  n_gap;
    logic [SUM_BITS:0]     n_isum_wide;
    logic [CO_W-1:0]       n_coal_wide;
    logic                  div_done;
    logic [SUM_BITS-1:0]   div_quo;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == {COUNT_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    always_comb begin
        n_mode      = t_mode'(i_mode);
        n_bad       = (i_send_outcome != OUTCOME_OK && i_send_outcome != OUTCOME_FAILED)
                      || (r_have_prev && i_timestamp_us < r_prev_time);
        n_gap       = i_timestamp_us - r_prev_time;
        n_isum_wide = {1'b0, r_isum} + (SUM_BITS+1)'(n_gap);
        n_coal_wide = CO_W'(r_coal) + CO_W'(i_merged_count);
    end

    ris_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_isum),
        .i_divisor  (r_icount),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_time <= '0;
            r_have_prev <= 1'b0;
            r_tick      <= '0;
            r_ok        <= '0;
            r_failed    <= '0;
            r_icount    <= '0;
            r_isum      <= '0;
            r_avg       <= '0;
            r_max       <= '0;
            r_accepted  <= '0;
            r_rejected  <= '0;
            r_coal      <= '0;
            r_status    <= STATUS_OK;
        end else begin
            if (i_cmd.apply) begin
                r_status <= (n_mode == MODE_TICK && n_bad) ? STATUS_INVALID : STATUS_OK;
                case (n_mode)
                    MODE_TICK: begin
                        if (!n_bad) begin
                            r_tick <= sat_inc(r_tick);
                            if (i_send_outcome == OUTCOME_OK) begin
                                r_ok <= sat_inc(r_ok);
                            end else begin
                                r_failed <= sat_inc(r_failed);
                            end
                            if (r_have_prev) begin
                                r_icount <= sat_inc(r_icount);
                                r_isum   <= n_isum_wide[SUM_BITS] ? {SUM_BITS{1'b1}}
                                                                  : n_isum_wide[SUM_BITS-1:0];
                                if (n_gap > r_max) begin
                                    r_max <= n_gap;
                                end
                            end
                            r_prev_time <= i_timestamp_us;
                            r_have_prev <= 1'b1;
                        end
                    end
                    MODE_ACCEPT: begin
                        r_accepted <= sat_inc(r_accepted);
                        r_coal     <= (n_coal_wide > CO_W'(TMAX)) ? TMAX
                                                                  : n_coal_wide[TIME_BITS-1:0];
                    end
                    MODE_REJECT: begin
                        r_rejected <= sat_inc(r_rejected);
                    end
                    default: begin
                    end
                endcase
            end
            if (div_done) begin
                r_avg <= (div_quo > TMAX_EXT) ? TMAX : div_quo[TIME_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_status <= r_status;
            r_out_data   <= OUT_W'({r_coal, r_rejected, r_accepted, r_max, r_avg,
                                    r_icount, r_failed, r_ok, r_tick});
        end
    end

    assign o_stat.need_div = (n_mode == MODE_TICK) && !n_bad && r_have_prev;
    assign o_stat.div_done = div_done;
    assign o_status        = r_out_status;
    assign o_data          = r_out_data;

endmodule

/* sv/ris_ctrl.sv */
module ris_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output ris_pkg::t_cmd   o_cmd,
    input  ris_pkg::t_stat  i_stat
);
    import ris_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_LOAD
    } t_state;

    t_state r_state;
    logic   r_in_ready;
    logic   r_out_valid;
    logic   r_div_start;
    logic   n_apply;
    logic   n_load;

    assign n_apply = i_in_valid && r_in_ready;
    assign n_load  = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= (r_state == S_IDLE) && n_apply && i_stat.need_div;
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_apply) begin
                        r_in_ready <= 1'b0;
                        if (i_stat.need_div) begin
                            r_state <= S_DIV;
                        end else begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_DIV: begin
                    if (i_stat.div_done) begin
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    if (n_load) begin
                        r_in_ready <= 1'b1;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd.apply     = n_apply;
    assign o_cmd.div_start = r_div_start;
    assign o_cmd.load      = n_load;
    assign o_in_ready      = r_in_ready;
    assign o_out_valid     = r_out_valid;

endmodule

/* tb/report_interval_statistics_test.sv */
`timescale 1ns / 100ps

module report_interval_statistics_test;
    import ris_pkg::*;

    localparam int TIME_W = 48;
    localparam int COUNT_W = 32;
    localparam int IN_W = ((TIME_W + 34 + 7) / 8) * 8;
    localparam int OUT_W = ((6 * COUNT_W + 3 * TIME_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 850;
    localparam int CYCLE_LIMIT = 500000;
    localparam int LONG_HOLD = 400;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic drain_first;
        t_mode mode;
        logic [TIME_W-1:0] stamp_us;
        logic [1:0] outcome;
        logic [31:0] coalesced;
    } stat_item_t;

    // Lowest bits hold tick_total, highest hold coalesced_sum, as on m_axis_tdata.
    typedef struct packed {
        logic [TIME_W-1:0] coalesced;
        logic [COUNT_W-1:0] rejected;
        logic [COUNT_W-1:0] accepted;
        logic [TIME_W-1:0] peak;
        logic [TIME_W-1:0] mean;
        logic [COUNT_W-1:0] intervals;
        logic [COUNT_W-1:0] fails;
        logic [COUNT_W-1:0] oks;
        logic [COUNT_W-1:0] ticks;
    } stats_word_t;

    typedef struct packed {
        logic status;
        stats_word_t stats;
    } snapshot_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    // timestamp_us, send_outcome, merged_count
    logic [IN_W-1:0] s_axis_tdata = '0;
    // mode
    logic [1:0] s_axis_tuser = 2'd0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // tick_total, send_ok_total, send_failed_total, interval_total_count, interval_average,
    // interval_maximum, accepted_total, rejected_total, coalesced_sum
    logic [OUT_W-1:0] m_axis_tdata;
    // status
    logic m_axis_tuser;

    report_interval_statistics dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    stat_item_t pending_items[$];
    snapshot_t expected_snapshots[$];
    int error_count = 0;
    int items_taken = 0;
    int results_seen = 0;
    int cycle_count = 0;
    bit in_taken = 1'b0;

    // Statistics as the block should hold them.
    logic [TIME_W-1:0] last_tick_us = '0;
    logic tick_seen = 1'b0;
    logic [COUNT_W-1:0] n_ticks = '0;
    logic [COUNT_W-1:0] n_ok = '0;
    logic [COUNT_W-1:0] n_failed = '0;
    logic [COUNT_W-1:0] n_intervals = '0;
    logic [63:0] interval_sum = '0;
    logic [TIME_W-1:0] mean_interval = '0;
    logic [TIME_W-1:0] peak_interval = '0;
    logic [COUNT_W-1:0] n_accepted = '0;
    logic [COUNT_W-1:0] n_rejected = '0;
    logic [TIME_W-1:0] coalesced_total = '0;

    // Timeline as the stimulus builder sees it, so that most ticks move forward.
    logic [TIME_W-1:0] plan_last_us = '0;
    logic plan_seen = 1'b0;

    function automatic logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    function automatic logic [TIME_W-1:0] rand48();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TIME_W-1:0];
    endfunction

    function automatic snapshot_t predict_stats(t_mode mode, logic [TIME_W-1:0] now_us,
                                               logic [1:0] outcome, logic [31:0] coal);
        snapshot_t s;
        logic [TIME_W-1:0] gap;
        logic [63:0] mean;
        logic [64:0] isum;
        logic [TIME_W:0] csum;
        s.status = STATUS_OK;
        case (mode)
            MODE_TICK: begin
                if (outcome != OUTCOME_OK && outcome != OUTCOME_FAILED) begin
                    s.status = STATUS_INVALID;
                end else if (tick_seen && now_us < last_tick_us) begin
                    s.status = STATUS_INVALID;
                end else begin
                    n_ticks = bump(n_ticks);
                    if (outcome == OUTCOME_OK) begin
                        n_ok = bump(n_ok);
                    end else begin
                        n_failed = bump(n_failed);
                    end
                    if (tick_seen) begin
                        gap = now_us - last_tick_us;
                        n_intervals = bump(n_intervals);
                        isum = {1'b0, interval_sum} + {{(65 - TIME_W){1'b0}}, gap};
                        interval_sum = isum[64] ? {64{1'b1}} : isum[63:0];
                        mean = interval_sum / {{(64 - COUNT_W){1'b0}}, n_intervals};
                        mean_interval = (mean > {{(64 - TIME_W){1'b0}}, TIME_MAX}) ?
                                        TIME_MAX : mean[TIME_W-1:0];
                        if (gap > peak_interval) begin
                            peak_interval = gap;
                        end
                    end
                    last_tick_us = now_us;
                    tick_seen = 1'b1;
                end
            end
            MODE_ACCEPT: begin
                n_accepted = bump(n_accepted);
                csum = {1'b0, coalesced_total} + {{(TIME_W - 31){1'b0}}, coal};
                coalesced_total = csum[TIME_W] ? TIME_MAX : csum[TIME_W-1:0];
            end
            MODE_REJECT: begin
                n_rejected = bump(n_rejected);
            end
            default: begin
            end
        endcase
        s.stats.ticks = n_ticks;
        s.stats.oks = n_ok;
        s.stats.fails = n_failed;
        s.stats.intervals = n_intervals;
        s.stats.mean = mean_interval;
        s.stats.peak = peak_interval;
        s.stats.accepted = n_accepted;
        s.stats.rejected = n_rejected;
        s.stats.coalesced = coalesced_total;
        return s;
    endfunction

    task automatic report_error(string msg);
        error_count++;
        $display("ERROR at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want) begin
            report_error($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    task automatic add_item(t_mode mode, logic [TIME_W-1:0] stamp, logic [1:0] outcome,
                            logic [31:0] coal, logic drain);
        stat_item_t it;
        it.drain_first = drain;
        it.mode = mode;
        it.stamp_us = stamp;
        it.outcome = outcome;
        it.coalesced = coal;
        pending_items.push_back(it);
        if (mode == MODE_TICK && outcome <= OUTCOME_FAILED
                && (!plan_seen || stamp >= plan_last_us)) begin
            plan_last_us = stamp;
            plan_seen = 1'b1;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    stat_item_t cur_item;
    int burst_left = 1;
    int idle_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && !in_taken)) begin
        end else if (idle_left != 0) begin
            s_axis_tvalid <= 1'b0;
            idle_left <= idle_left - 1;
        end else if (pending_items.size() == 0
                || (pending_items[0].drain_first && expected_snapshots.size() != 0)) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            cur_item = pending_items.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= {{(IN_W - TIME_W - 34){1'b0}}, cur_item.coalesced,
                             cur_item.outcome, cur_item.stamp_us};
            s_axis_tuser <= cur_item.mode;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(40, 1);
                idle_left <= ($urandom_range(9, 0) < 3) ? 0 : $urandom_range(12, 1);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver: stall pattern changes per phase, with one long hold-off.
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    int phase_left = 0;
    int stall_style = 0;

    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (!long_hold_done && results_seen >= 200) begin
            m_axis_tready <= 1'b0;
            hold_left <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else begin
            if (phase_left == 0) begin
                phase_left <= $urandom_range(80, 10);
                stall_style <= $urandom_range(2, 0);
            end else begin
                phase_left <= phase_left - 1;
            end
            case (stall_style)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(1, 0));
                default: m_axis_tready <= ($urandom_range(7, 0) == 0);
            endcase
        end
    end

    // Input transfers feed the prediction; output transfers are checked against it.
    snapshot_t got_snap;
    snapshot_t want_snap;

    always @(posedge i_clk) begin
        cycle_count++;
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken) begin
            items_taken++;
            expected_snapshots.push_back(predict_stats(t_mode'(s_axis_tuser),
                s_axis_tdata[TIME_W-1:0], s_axis_tdata[TIME_W+1:TIME_W],
                s_axis_tdata[TIME_W+33:TIME_W+2]));
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            got_snap.status = m_axis_tuser;
            got_snap.stats = m_axis_tdata;
            if (expected_snapshots.size() == 0) begin
                report_error("result transfer with no item outstanding");
            end else begin
                want_snap = expected_snapshots.pop_front();
                check_field("status", got_snap.status, want_snap.status);
                check_field("tick_total", got_snap.stats.ticks, want_snap.stats.ticks);
                check_field("send_ok_total", got_snap.stats.oks, want_snap.stats.oks);
                check_field("send_failed_total", got_snap.stats.fails,
                            want_snap.stats.fails);
                check_field("interval_total_count", got_snap.stats.intervals,
                            want_snap.stats.intervals);
                check_field("interval_average", got_snap.stats.mean, want_snap.stats.mean);
                check_field("interval_maximum", got_snap.stats.peak, want_snap.stats.peak);
                check_field("accepted_total", got_snap.stats.accepted,
                            want_snap.stats.accepted);
                check_field("rejected_total", got_snap.stats.rejected,
                            want_snap.stats.rejected);
                check_field("coalesced_sum", got_snap.stats.coalesced,
                            want_snap.stats.coalesced);
            end
        end
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        int total_items;
        int pick;
        int sub;
        logic [31:0] coal;
        logic [31:0] r_lo;
        logic [31:0] r_hi;
        logic [TIME_W-1:0] gap;
        logic drain;

        add_item(MODE_READ, rand48(), 2'($urandom_range(3, 0)), $urandom, 1'b0);
        add_item(MODE_TICK, '0, OUTCOME_OK, $urandom, 1'b0);
        add_item(MODE_TICK, '0, OUTCOME_FAILED, $urandom, 1'b0);
        add_item(MODE_TICK, rand48(), 2'd2, $urandom, 1'b0);
        add_item(MODE_TICK, TIME_MAX, 2'd3, $urandom, 1'b0);
        add_item(MODE_TICK, 48'd1000, OUTCOME_OK, $urandom, 1'b0);
        add_item(MODE_TICK, 48'd999, OUTCOME_OK, $urandom, 1'b0);
        add_item(MODE_TICK, '0, OUTCOME_FAILED, $urandom, 1'b0);
        add_item(MODE_TICK, 48'd1000, OUTCOME_FAILED, $urandom, 1'b0);
        add_item(MODE_ACCEPT, rand48(), 2'($urandom_range(3, 0)), 32'd0, 1'b0);
        add_item(MODE_ACCEPT, rand48(), 2'($urandom_range(3, 0)), 32'hFFFF_FFFF, 1'b0);
        add_item(MODE_ACCEPT, TIME_MAX, 2'd3, 32'hFFFF_FFFF, 1'b0);
        add_item(MODE_REJECT, TIME_MAX, 2'd3, 32'hFFFF_FFFF, 1'b0);
        add_item(MODE_REJECT, '0, 2'd0, 32'd0, 1'b0);
        add_item(MODE_READ, TIME_MAX, 2'd3, 32'hFFFF_FFFF, 1'b0);
        add_item(MODE_TICK, 48'd1001, OUTCOME_OK, $urandom, 1'b0);
        add_item(MODE_TICK, 48'd5_000_000, OUTCOME_OK, $urandom, 1'b0);
        add_item(MODE_TICK, 48'd5_000_001, OUTCOME_FAILED, $urandom, 1'b1);
        add_item(MODE_READ, rand48(), 2'($urandom_range(3, 0)), $urandom, 1'b0);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            drain = (k % 150 == 149);
            pick = $urandom_range(99, 0);
            sub = $urandom_range(9, 0);
            coal = (sub == 0) ? 32'd0 : (sub == 1) ? 32'hFFFF_FFFF : $urandom;
            if (pick < 45) begin
                sub = $urandom_range(99, 0);
                if (sub < 70) begin
                    r_lo = $urandom;
                    r_hi = $urandom_range(15, 0);
                    case ($urandom_range(9, 0))
                        0: gap = '0;
                        1, 2, 3, 4, 5: gap = TIME_W'($urandom_range(5000, 1));
                        6, 7, 8: gap = TIME_W'($urandom_range(24'hFF_FFFF, 1));
                        default: gap = TIME_W'({r_hi[3:0], r_lo});
                    endcase
                    add_item(MODE_TICK, plan_last_us + gap, 2'($urandom_range(1, 0)), coal,
                             drain);
                end else if (sub < 85 && plan_last_us != 0) begin
                    add_item(MODE_TICK, rand48() % plan_last_us, 2'($urandom_range(1, 0)),
                             coal, drain);
                end else begin
                    add_item(MODE_TICK, rand48(), 2'($urandom_range(3, 2)), coal, drain);
                end
            end else if (pick < 65) begin
                add_item(MODE_ACCEPT, rand48(), 2'($urandom_range(3, 0)), coal, drain);
            end else if (pick < 80) begin
                add_item(MODE_REJECT, rand48(), 2'($urandom_range(3, 0)), coal, drain);
            end else begin
                add_item(MODE_READ, rand48(), 2'($urandom_range(3, 0)), coal, drain);
            end
        end

        // The top of the timeline comes last, since no later tick may go below it.
        add_item(MODE_TICK, TIME_MAX, OUTCOME_OK, $urandom, 1'b1);
        add_item(MODE_TICK, TIME_MAX, OUTCOME_FAILED, $urandom, 1'b0);
        add_item(MODE_TICK, '0, OUTCOME_OK, $urandom, 1'b0);
        add_item(MODE_READ, rand48(), 2'($urandom_range(3, 0)), $urandom, 1'b0);
        total_items = pending_items.size();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (items_taken != total_items) @(posedge i_clk);
        while (expected_snapshots.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && expected_snapshots.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* report_interval_statistics.f */
sv/ris_pkg.sv
sv/ris_div.sv
sv/ris_datapath.sv
sv/ris_ctrl.sv
sv/report_interval_statistics.sv
tb/report_interval_statistics_test.sv
